/* rtl/ppr_pkg.sv */
// Shared types and constants for the pairing packet receiver.
// Holds command, mode and register codes and the packet layout.
// No dependencies; every other file in this folder uses it.
`default_nettype none

package ppr_pkg;

    // Bitmap geometry.
    localparam int BITMAP_WORDS_DEF = 4;
    localparam int WORD_W           = 32;

    // Input commands, carried in the input tuser.
    localparam logic [1:0] CMD_START_SCAN = 2'd0;
    localparam logic [1:0] CMD_START_BOND = 2'd1;
    localparam logic [1:0] CMD_BYTE       = 2'd2;
    localparam logic [1:0] CMD_READ_WORD  = 2'd3;

    // Operating modes.
    localparam logic [2:0] MODE_IDLE    = 3'd0;
    localparam logic [2:0] MODE_SCAN    = 3'd1;
    localparam logic [2:0] MODE_BONDING = 3'd2;
    localparam logic [2:0] MODE_BOND    = 3'd3;
    localparam logic [2:0] MODE_BONDED  = 3'd4;

    // Result kinds, carried in the output tuser.
    localparam logic KIND_VERDICT = 1'b0;
    localparam logic KIND_WORD    = 1'b1;

    // Configuration register indexes.
    localparam logic [2:0] CFG_HEADER_LOW         = 3'd0;
    localparam logic [2:0] CFG_HEADER_HIGH        = 3'd1;
    localparam logic [2:0] CFG_OWN_DEVICE_ID      = 3'd2;
    localparam logic [2:0] CFG_CODE_BOND          = 3'd3;
    localparam logic [2:0] CFG_CODE_UNBOND        = 3'd4;
    localparam logic [2:0] CFG_CODE_UNBOND_FORCE  = 3'd5;
    localparam logic [2:0] CFG_CODE_BOND_DEVICE   = 3'd6;
    localparam logic [2:0] CFG_CODE_UNBOND_DEVICE = 3'd7;

    // Reset values of the type codes.
    localparam logic [7:0] RST_CODE_BOND          = 8'd0;
    localparam logic [7:0] RST_CODE_UNBOND        = 8'd1;
    localparam logic [7:0] RST_CODE_UNBOND_FORCE  = 8'd2;
    localparam logic [7:0] RST_CODE_BOND_DEVICE   = 8'd3;
    localparam logic [7:0] RST_CODE_UNBOND_DEVICE = 8'd4;

    // Packet layout, as byte positions.
    localparam logic [4:0] POS_SHORT_END = 5'd6;
    localparam logic [4:0] POS_HDR_END   = 5'd10;
    localparam logic [4:0] POS_ID        = 5'd10;
    localparam logic [4:0] POS_ID_END    = 5'd14;
    localparam logic [4:0] POS_CHANNEL   = 5'd14;
    localparam logic [4:0] POS_TYPE      = 5'd18;
    localparam logic [4:0] POS_FLAGS     = 5'd19;
    localparam logic [4:0] POS_PEER      = 5'd20;
    localparam logic [4:0] POS_PEER_END  = 5'd24;
    localparam logic [4:0] MIN_PACKET    = 5'd24;
    localparam logic [4:0] POS_MAX       = 5'd31;

    // Flag bits of byte 19.
    localparam logic [7:0] FLAG_RECEIVER = 8'h02;
    localparam logic [7:0] FLAG_FINISH   = 8'h04;

endpackage

`default_nettype wire

/* rtl/ppr_bitmap.sv */
// Used-channel bitmap memory of the pairing packet receiver.
// One synchronous read port and one read-modify-write bit set port,
// with per-word valid flags for the clear. Depends on ppr_pkg.
`default_nettype none

module ppr_bitmap #(
    parameter int BITMAP_WORDS = ppr_pkg::BITMAP_WORDS_DEF
) (
    input  wire logic                                      aclk,
    input  wire logic                                      aresetn,
    input  wire logic                                      clear,
    input  wire logic                                      rd_en,
    input  wire logic [((BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1)-1:0] rd_addr,
    output logic      [ppr_pkg::WORD_W-1:0]                rd_data,
    input  wire logic                                      set_en,
    input  wire logic [((BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1)-1:0] set_addr,
    input  wire logic [4:0]                                set_bit
);

    localparam int ADDR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;

    logic [ppr_pkg::WORD_W-1:0] mem [BITMAP_WORDS];
    logic [ppr_pkg::WORD_W-1:0] rd_data_reg;
    logic [BITMAP_WORDS-1:0]    valid_reg;
    logic [ppr_pkg::WORD_W-1:0] set_data;

    // The word being set was read when its packet ended; merge the new bit.
    assign set_data = rd_data_reg | (ppr_pkg::WORD_W'(1) << set_bit);
    assign rd_data  = rd_data_reg;

    // Memory write and registered read, forwarding a write to the same word.
    always_ff @(posedge aclk) begin
        if (set_en) begin
            mem[set_addr] <= set_data;
        end
        if (rd_en) begin
            if (set_en && (set_addr == rd_addr)) begin
                rd_data_reg <= set_data;
            end else if (valid_reg[rd_addr]) begin
                rd_data_reg <= mem[rd_addr];
            end else begin
                rd_data_reg <= '0;
            end
        end
    end

    // A word that was never set since the last clear reads as zero.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else if (clear) begin
            valid_reg <= '0;
        end else if (set_en) begin
            valid_reg[set_addr] <= 1'b1;
        end
    end

`ifndef NO_ASSERTIONS
    a_clear_empties: assert property (@(posedge aclk) disable iff (!aresetn)
        clear |=> (valid_reg == '0))
        else $error("bitmap valid flags not cleared");

    a_set_marks_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        (set_en && !clear) |=> valid_reg[$past(set_addr)])
        else $error("bitmap word not valid after a set");

    a_forward_bit: assert property (@(posedge aclk) disable iff (!aresetn)
        (rd_en && set_en && (rd_addr == set_addr)) |=> rd_data_reg[$past(set_bit)])
        else $error("forwarded bitmap word lost the set bit");
`endif

endmodule

`default_nettype wire

/* rtl/pairing_packet_receiver.sv */
// Pairing packet receiver: packet parsing, pairing handshake and result stage.
// Instantiates ppr_bitmap for the used-channel memory; depends on ppr_pkg.
// Configuration registers live here and are written through the cfg channel.
//
// The block takes one item per clock while results are being taken: start
// commands, packet bytes and bitmap reads may follow each other in every
// cycle. A result passes through the result stage, where its bitmap word is
// read, and then through the output register. The used-channel bitmap is a
// BITMAP_WORDS by 32 memory with one read and one write port; a marking
// packet reads its word when its last byte is taken and writes it back when
// its result moves into the output register, and a read of the same word in
// the cycle of that write is served from the write data. Start scan clears
// the bitmap at once through per-word valid flags, so there is no clearing
// pass. Input stalls while the result stage holds an item that cannot move on.
`default_nettype none

module pairing_packet_receiver #(
    parameter int BITMAP_WORDS = ppr_pkg::BITMAP_WORDS_DEF
) (
    input  wire logic        aclk,
    input  wire logic        aresetn,
    // Input stream.
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [23:0] s_tdata,   // data_byte[7:0], start_type[15:8], word_index[17:16]
    input  wire logic [1:0]  s_tuser,   // command[1:0]
    input  wire logic        s_tlast,
    // Result stream.
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [79:0]      m_tdata,   // mode_now[2:0], restart_receive[3], channel_marked[4],
                                        // entered_bond[5], expected_type[13:6],
                                        // peer_id[45:14], bitmap_word[77:46]
    output logic             m_tuser,   // result_kind[0]
    // Configuration writes.
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [2:0]  cfg_index,
    input  wire logic [47:0] cfg_data
);

    localparam int ADDR_W = (BITMAP_WORDS > 1) ? $clog2(BITMAP_WORDS) : 1;
    localparam logic [3:0] WORDS_LIM = 4'(BITMAP_WORDS);

    // Configuration registers.
    logic [47:0] hdr_low_reg;
    logic [31:0] hdr_high_reg;
    logic [31:0] own_id_reg;
    logic [7:0]  code_bond_reg, code_unbond_reg, code_force_reg;
    logic [7:0]  code_bdev_reg, code_udev_reg;

    // Handshake state.
    logic [2:0]  mode_reg, mode_next;
    logic [7:0]  expected_reg, expected_next;
    logic [31:0] conn_id_reg, conn_id_next;

    // Packet in progress.
    logic [4:0]  pos_reg, pos_next;
    logic        short_ok_reg, short_ok_next;
    logic        long_ok_reg, long_ok_next;
    logic [31:0] pkt_id_reg, pkt_id_next;
    logic [7:0]  pkt_chan_reg, pkt_chan_next;
    logic [7:0]  pkt_type_reg, pkt_type_next;
    logic [7:0]  pkt_flags_reg, pkt_flags_next;
    logic [31:0] pkt_peer_reg, pkt_peer_next;

    // Result stage after the memory read.
    logic        s1_valid_reg;
    logic        s1_kind_reg;
    logic [2:0]  s1_mode_reg;
    logic        s1_restart_reg, s1_marked_reg, s1_entered_reg;
    logic [7:0]  s1_expected_reg;
    logic [31:0] s1_peer_reg;
    logic        s1_word_ok_reg;
    logic [ADDR_W-1:0] s1_addr_reg;
    logic [4:0]  s1_bit_reg;

    // Output register.
    logic        m_tvalid_reg;
    logic        out_kind_reg;
    logic [2:0]  out_mode_reg;
    logic        out_restart_reg, out_marked_reg, out_entered_reg;
    logic [7:0]  out_expected_reg;
    logic [31:0] out_peer_reg;
    logic [31:0] out_word_reg;

    // Input fields.
    logic [1:0]  command;
    logic [7:0]  data_byte;
    logic [7:0]  start_type;
    logic [1:0]  word_index;

    logic        s_fire, out_free, s1_go;
    logic        gives_result;
    logic        restart, marked, entered;
    logic        long_enough, id_ok, is_bond_req, is_confirm;
    logic [2:0]  word_sel;
    logic        word_in_range;
    logic [2:0]  hl_sel;
    logic [1:0]  hh_sel, id_sel, peer_sel;
    logic [7:0]  want_low, want_high;
    logic [31:0] bm_rd_data;

    assign command    = s_tuser;
    assign data_byte  = s_tdata[7:0];
    assign start_type = s_tdata[15:8];
    assign word_index = s_tdata[17:16];

    // Flow control: the result stage moves when the output register is free.
    assign out_free = !m_tvalid_reg || m_tready;
    assign s1_go    = s1_valid_reg && out_free;
    assign s_tready = !s1_valid_reg || out_free;
    assign s_fire   = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    // Configuration writes.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            hdr_low_reg     <= '0;
            hdr_high_reg    <= '0;
            own_id_reg      <= '0;
            code_bond_reg   <= ppr_pkg::RST_CODE_BOND;
            code_unbond_reg <= ppr_pkg::RST_CODE_UNBOND;
            code_force_reg  <= ppr_pkg::RST_CODE_UNBOND_FORCE;
            code_bdev_reg   <= ppr_pkg::RST_CODE_BOND_DEVICE;
            code_udev_reg   <= ppr_pkg::RST_CODE_UNBOND_DEVICE;
        end else if (cfg_valid) begin
            case (cfg_index)
                ppr_pkg::CFG_HEADER_LOW:         hdr_low_reg     <= cfg_data;
                ppr_pkg::CFG_HEADER_HIGH:        hdr_high_reg    <= cfg_data[31:0];
                ppr_pkg::CFG_OWN_DEVICE_ID:      own_id_reg      <= cfg_data[31:0];
                ppr_pkg::CFG_CODE_BOND:          code_bond_reg   <= cfg_data[7:0];
                ppr_pkg::CFG_CODE_UNBOND:        code_unbond_reg <= cfg_data[7:0];
                ppr_pkg::CFG_CODE_UNBOND_FORCE:  code_force_reg  <= cfg_data[7:0];
                ppr_pkg::CFG_CODE_BOND_DEVICE:   code_bdev_reg   <= cfg_data[7:0];
                ppr_pkg::CFG_CODE_UNBOND_DEVICE: code_udev_reg   <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // Byte selects for the header compare and field assembly.
    assign hl_sel    = pos_reg[2:0];
    assign hh_sel    = 2'(pos_reg - ppr_pkg::POS_SHORT_END);
    assign id_sel    = 2'(pos_reg - ppr_pkg::POS_ID);
    assign peer_sel  = 2'(pos_reg - ppr_pkg::POS_PEER);
    assign want_low  = hdr_low_reg[{hl_sel, 3'b000} +: 8];
    assign want_high = hdr_high_reg[{hh_sel, 3'b000} +: 8];

    // Take the current byte into the packet being assembled.
    always_comb begin
        short_ok_next  = short_ok_reg;
        long_ok_next   = long_ok_reg;
        pkt_id_next    = pkt_id_reg;
        pkt_chan_next  = pkt_chan_reg;
        pkt_type_next  = pkt_type_reg;
        pkt_flags_next = pkt_flags_reg;
        pkt_peer_next  = pkt_peer_reg;
        if (pos_reg < ppr_pkg::POS_SHORT_END) begin
            if (data_byte != want_low) begin
                short_ok_next = 1'b0;
                long_ok_next  = 1'b0;
            end
        end else if (pos_reg < ppr_pkg::POS_HDR_END) begin
            if (data_byte != want_high) begin
                long_ok_next = 1'b0;
            end
        end else if (pos_reg < ppr_pkg::POS_ID_END) begin
            pkt_id_next[{id_sel, 3'b000} +: 8] = data_byte;
        end else if (pos_reg == ppr_pkg::POS_CHANNEL) begin
            pkt_chan_next = data_byte;
        end else if (pos_reg == ppr_pkg::POS_TYPE) begin
            pkt_type_next = data_byte;
        end else if (pos_reg == ppr_pkg::POS_FLAGS) begin
            pkt_flags_next = data_byte;
        end else if ((pos_reg >= ppr_pkg::POS_PEER) && (pos_reg < ppr_pkg::POS_PEER_END)) begin
            pkt_peer_next[{peer_sel, 3'b000} +: 8] = data_byte;
        end
        pos_next = (pos_reg < ppr_pkg::POS_MAX) ? (pos_reg + 5'd1) : pos_reg;
    end

    // Bitmap word selection, from the read command or the packet's channel.
    assign word_sel      = (command == ppr_pkg::CMD_READ_WORD) ? {1'b0, word_index}
                                                                : pkt_chan_next[7:5];
    assign word_in_range = ({1'b0, word_sel} < WORDS_LIM);

    // Verdict of a packet that ends with this byte.
    assign long_enough = (pos_next >= ppr_pkg::MIN_PACKET);
    assign id_ok       = (pkt_id_next == own_id_reg);
    assign is_bond_req = (pkt_type_next == code_bond_reg) ||
                         (pkt_type_next == code_unbond_reg) ||
                         (pkt_type_next == code_force_reg);
    assign is_confirm  = (pkt_type_next == code_bdev_reg) ||
                         (pkt_type_next == code_udev_reg);

    always_comb begin
        mode_next     = mode_reg;
        expected_next = expected_reg;
        conn_id_next  = conn_id_reg;
        restart       = 1'b0;
        marked        = 1'b0;
        entered       = 1'b0;
        case (mode_reg)
            ppr_pkg::MODE_SCAN: begin
                if (long_enough && short_ok_next) begin
                    restart = 1'b1;
                    marked  = word_in_range;
                end
            end
            ppr_pkg::MODE_BONDING: begin
                if (long_enough && long_ok_next) begin
                    if ((pkt_flags_next & ppr_pkg::FLAG_RECEIVER) == 8'd0) begin
                        restart = 1'b1;
                    end else if ((pkt_type_next == expected_reg) && id_ok && is_bond_req) begin
                        mode_next     = ppr_pkg::MODE_BOND;
                        conn_id_next  = pkt_peer_next;
                        expected_next = (pkt_type_next == code_bond_reg) ? code_bdev_reg
                                                                          : code_udev_reg;
                        entered       = 1'b1;
                    end else if ((pkt_type_next == expected_reg) && id_ok && is_confirm) begin
                        if ((pkt_peer_next == conn_id_reg) &&
                            ((pkt_flags_next & ppr_pkg::FLAG_FINISH) != 8'd0)) begin
                            mode_next = ppr_pkg::MODE_BONDED;
                        end
                    end else begin
                        restart = 1'b1;
                    end
                end
            end
            default: ;
        endcase
    end

    assign gives_result = (command == ppr_pkg::CMD_READ_WORD) ||
                          ((command == ppr_pkg::CMD_BYTE) && s_tlast);

    // Handshake and packet state update on each accepted item other than a bitmap read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg      <= ppr_pkg::MODE_IDLE;
            expected_reg  <= '0;
            conn_id_reg   <= '0;
            pos_reg       <= '0;
            short_ok_reg  <= 1'b1;
            long_ok_reg   <= 1'b1;
            pkt_id_reg    <= '0;
            pkt_chan_reg  <= '0;
            pkt_type_reg  <= '0;
            pkt_flags_reg <= '0;
            pkt_peer_reg  <= '0;
        end else if (s_fire && (command != ppr_pkg::CMD_READ_WORD)) begin
            if ((command == ppr_pkg::CMD_BYTE) && !s_tlast) begin
                pos_reg       <= pos_next;
                short_ok_reg  <= short_ok_next;
                long_ok_reg   <= long_ok_next;
                pkt_id_reg    <= pkt_id_next;
                pkt_chan_reg  <= pkt_chan_next;
                pkt_type_reg  <= pkt_type_next;
                pkt_flags_reg <= pkt_flags_next;
                pkt_peer_reg  <= pkt_peer_next;
            end else begin
                // Start commands and packet ends leave an empty packet behind.
                pos_reg       <= '0;
                short_ok_reg  <= 1'b1;
                long_ok_reg   <= 1'b1;
                pkt_id_reg    <= '0;
                pkt_chan_reg  <= '0;
                pkt_type_reg  <= '0;
                pkt_flags_reg <= '0;
                pkt_peer_reg  <= '0;
                case (command)
                    ppr_pkg::CMD_START_SCAN: mode_reg <= ppr_pkg::MODE_SCAN;
                    ppr_pkg::CMD_START_BOND: begin
                        mode_reg     <= ppr_pkg::MODE_BONDING;
                        expected_reg <= start_type;
                    end
                    default: begin
                        mode_reg     <= mode_next;
                        expected_reg <= expected_next;
                        conn_id_reg  <= conn_id_next;
                    end
                endcase
            end
        end
    end

    // Result stage: holds an item while its bitmap word is read.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (s_fire && gives_result) begin
            s1_valid_reg <= 1'b1;
        end else if (s1_go) begin
            s1_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire && gives_result) begin
            if (command == ppr_pkg::CMD_READ_WORD) begin
                s1_kind_reg     <= ppr_pkg::KIND_WORD;
                s1_mode_reg     <= mode_reg;
                s1_restart_reg  <= 1'b0;
                s1_marked_reg   <= 1'b0;
                s1_entered_reg  <= 1'b0;
                s1_expected_reg <= expected_reg;
                s1_peer_reg     <= conn_id_reg;
                s1_word_ok_reg  <= word_in_range;
            end else begin
                s1_kind_reg     <= ppr_pkg::KIND_VERDICT;
                s1_mode_reg     <= mode_next;
                s1_restart_reg  <= restart;
                s1_marked_reg   <= marked;
                s1_entered_reg  <= entered;
                s1_expected_reg <= expected_next;
                s1_peer_reg     <= conn_id_next;
                s1_word_ok_reg  <= 1'b0;
            end
            s1_addr_reg <= word_sel[ADDR_W-1:0];
            s1_bit_reg  <= pkt_chan_next[4:0];
        end
    end

    // Bitmap memory.
    ppr_bitmap #(
        .BITMAP_WORDS(BITMAP_WORDS)
    ) u_bitmap (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .clear    (s_fire && (command == ppr_pkg::CMD_START_SCAN)),
        .rd_en    (s_fire && gives_result && word_in_range &&
                   ((command == ppr_pkg::CMD_READ_WORD) || marked)),
        .rd_addr  (word_sel[ADDR_W-1:0]),
        .rd_data  (bm_rd_data),
        .set_en   (s1_go && s1_marked_reg),
        .set_addr (s1_addr_reg),
        .set_bit  (s1_bit_reg)
    );

    // Output register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_tvalid_reg <= 1'b0;
        end else if (s1_go) begin
            m_tvalid_reg <= 1'b1;
        end else if (m_tready) begin
            m_tvalid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_go) begin
            out_kind_reg     <= s1_kind_reg;
            out_mode_reg     <= s1_mode_reg;
            out_restart_reg  <= s1_restart_reg;
            out_marked_reg   <= s1_marked_reg;
            out_entered_reg  <= s1_entered_reg;
            out_expected_reg <= s1_expected_reg;
            out_peer_reg     <= s1_peer_reg;
            out_word_reg     <= s1_word_ok_reg ? bm_rd_data : 32'd0;
        end
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tuser  = out_kind_reg;
    assign m_tdata  = {2'b00, out_word_reg, out_peer_reg, out_expected_reg,
                       out_entered_reg, out_marked_reg, out_restart_reg, out_mode_reg};

`ifndef NO_ASSERTIONS
    a_stall_blocks_input: assert property (@(posedge aclk) disable iff (!aresetn)
        (s1_valid_reg && !out_free) |-> !s_tready)
        else $error("input taken while the result stage is stalled");

    a_marked_restarts: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && out_marked_reg) |-> (out_restart_reg &&
                                              (out_kind_reg == ppr_pkg::KIND_VERDICT)))
        else $error("marked channel without a restart verdict");

    a_word_only_on_read: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid_reg && (out_kind_reg == ppr_pkg::KIND_VERDICT)) |-> (out_word_reg == 32'd0))
        else $error("bitmap word in a packet verdict");
`endif

endmodule

`default_nettype wire

/* test/tb_pairing_packet_receiver.sv */
// Self-checking testbench for the pairing packet receiver.
// Drives commands and packet bytes and compares every result with a behavioural predictor,
// or with a fixed expected result for some directed rows. Depends on ppr_pkg and the pairing_packet_receiver RTL only.
`timescale 1ns / 1ps

module tb_pairing_packet_receiver;
    import ppr_pkg::*;

    localparam int MAP_WORDS     = BITMAP_WORDS_DEF;
    localparam int PHASES        = 6;
    localparam int PHASE_ITEMS   = 280;
    localparam int SETTLE_CYCLES = 8;
    localparam int QUIET_LIMIT   = 2000;

    // One result, held in the same field order as the result stream.
    typedef struct packed {
        logic        kind;
        logic [2:0]  mode;
        logic        restart;
        logic        marked;
        logic        entered;
        logic [7:0]  etype;
        logic [31:0] peer;
        logic [31:0] word;
    } ppr_result_t;

    // One row of the directed stimulus: a single item or a whole packet.
    typedef struct {
        logic        is_pkt;
        logic [1:0]  cmd;
        logic [7:0]  arg;
        logic        last;
        int          len;
        int          bad_at;
        logic [7:0]  chan;
        logic [7:0]  ptype;
        logic [7:0]  flags;
        logic [31:0] id;
        logic [31:0] peer;
        logic        typed;
        ppr_result_t want;
    } row_t;

    logic        aclk      = 1'b0;
    logic        aresetn   = 1'b0;
    logic        s_tvalid  = 1'b0;
    logic        s_tready;
    logic [23:0] s_tdata   = '0;   // data_byte[7:0], start_type[15:8], word_index[17:16]
    logic [1:0]  s_tuser   = CMD_BYTE;   // command[1:0]
    logic        s_tlast   = 1'b0;
    logic        m_tvalid;
    logic        m_tready  = 1'b0;
    logic [79:0] m_tdata;          // mode_now[2:0], restart_receive[3], channel_marked[4],
                                   // entered_bond[5], expected_type[13:6], peer_id[45:14],
                                   // bitmap_word[77:46]
    logic        m_tuser;          // result_kind[0]
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [2:0]  cfg_index = CFG_HEADER_LOW;
    logic [47:0] cfg_data  = '0;

    // Predictor configuration, starting from the register reset values.
    logic [47:0] c_hdr_lo = '0;
    logic [31:0] c_hdr_hi = '0;
    logic [31:0] c_own    = '0;
    logic [7:0]  c_bond   = RST_CODE_BOND;
    logic [7:0]  c_unbond = RST_CODE_UNBOND;
    logic [7:0]  c_force  = RST_CODE_UNBOND_FORCE;
    logic [7:0]  c_bdev   = RST_CODE_BOND_DEVICE;
    logic [7:0]  c_udev   = RST_CODE_UNBOND_DEVICE;

    // Predictor state: pairing progress, packet being assembled and channel bitmap.
    logic [2:0]  pm_mode  = MODE_IDLE;
    logic [7:0]  pm_etype = '0;
    logic [31:0] pm_peer  = '0;
    logic [31:0] pm_map [MAP_WORDS];
    logic [4:0]  pk_pos   = '0;
    logic        pk_short_ok = 1'b1;
    logic        pk_long_ok  = 1'b1;
    logic [31:0] pk_id    = '0;
    logic [7:0]  pk_chan  = '0;
    logic [7:0]  pk_type  = '0;
    logic [7:0]  pk_flags = '0;
    logic [31:0] pk_peer  = '0;

    ppr_result_t awaited_results [$];
    int          mismatches  = 0;
    int          sent_items  = 0;
    int          burst_left  = 0;
    int          gaps_on     = 1;
    int          ready_style = 1;
    int          stall_left  = 0;
    int          ready_tick  = 0;
    int          quiet_cycles = 0;

    pairing_packet_receiver #(.BITMAP_WORDS(MAP_WORDS)) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .s_tlast   (s_tlast),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // 50 MHz clock.
    always begin
        #10 aclk = 1'b1;
        #10 aclk = 1'b0;
    end

    initial begin
        foreach (pm_map[i]) pm_map[i] = '0;
    end

    // Forget the packet in progress.
    function automatic void clear_packet();
        pk_pos      = '0;
        pk_short_ok = 1'b1;
        pk_long_ok  = 1'b1;
        pk_id       = '0;
        pk_chan     = '0;
        pk_type     = '0;
        pk_flags    = '0;
        pk_peer     = '0;
    endfunction

    // Advance the pairing state by one accepted item and work out its result, if any.
    task automatic advance_pairing(input logic [1:0] cmd, input logic [7:0] data,
                                   input logic last, input logic [7:0] st,
                                   input logic [1:0] widx, output logic has,
                                   output ppr_result_t r);
        int         p;
        logic [2:0] w;
        logic       id_ok;
        logic [7:0] t;
        has = 1'b0;
        r   = '0;
        case (cmd)
            CMD_START_SCAN: begin
                pm_mode = MODE_SCAN;
                foreach (pm_map[i]) pm_map[i] = '0;
                clear_packet();
            end
            CMD_START_BOND: begin
                pm_mode  = MODE_BONDING;
                pm_etype = st;
                clear_packet();
            end
            CMD_READ_WORD: begin
                has    = 1'b1;
                r.kind = KIND_WORD;
                r.word = (int'(widx) < MAP_WORDS) ? pm_map[widx] : '0;
            end
            default: begin
                // Collect the byte into the header checks and packet fields.
                p = int'(pk_pos);
                if (p < int'(POS_SHORT_END)) begin
                    if (data != c_hdr_lo[8*p +: 8]) begin
                        pk_short_ok = 1'b0;
                        pk_long_ok  = 1'b0;
                    end
                end else if (p < int'(POS_HDR_END)) begin
                    if (data != c_hdr_hi[8*(p-int'(POS_SHORT_END)) +: 8]) pk_long_ok = 1'b0;
                end else if (p < int'(POS_ID_END)) begin
                    pk_id[8*(p-int'(POS_ID)) +: 8] = data;
                end else if (p == int'(POS_CHANNEL)) begin
                    pk_chan = data;
                end else if (p == int'(POS_TYPE)) begin
                    pk_type = data;
                end else if (p == int'(POS_FLAGS)) begin
                    pk_flags = data;
                end else if (p >= int'(POS_PEER) && p < int'(POS_PEER_END)) begin
                    pk_peer[8*(p-int'(POS_PEER)) +: 8] = data;
                end
                if (pk_pos < POS_MAX) pk_pos = pk_pos + 5'd1;

                // The final byte gives the verdict.
                if (last) begin
                    has    = 1'b1;
                    r.kind = KIND_VERDICT;
                    if (pm_mode == MODE_SCAN) begin
                        if (pk_pos >= MIN_PACKET && pk_short_ok) begin
                            r.restart = 1'b1;
                            w = pk_chan[7:5];
                            if (int'(w) < MAP_WORDS) begin
                                pm_map[w][pk_chan[4:0]] = 1'b1;
                                r.marked = 1'b1;
                            end
                        end
                    end else if (pm_mode == MODE_BONDING) begin
                        if (pk_pos >= MIN_PACKET && pk_long_ok) begin
                            t     = pk_type;
                            id_ok = (pk_id == c_own);
                            if ((pk_flags & FLAG_RECEIVER) == 8'h00) begin
                                r.restart = 1'b1;
                            end else if (t == pm_etype && id_ok &&
                                         (t == c_bond || t == c_unbond || t == c_force)) begin
                                pm_mode   = MODE_BOND;
                                pm_peer   = pk_peer;
                                pm_etype  = (t == c_bond) ? c_bdev : c_udev;
                                r.entered = 1'b1;
                            end else if (t == pm_etype && id_ok &&
                                         (t == c_bdev || t == c_udev)) begin
                                if (pk_peer == pm_peer && (pk_flags & FLAG_FINISH) != 8'h00)
                                    pm_mode = MODE_BONDED;
                            end else begin
                                r.restart = 1'b1;
                            end
                        end
                    end
                    clear_packet();
                end
            end
        endcase
        r.mode  = pm_mode;
        r.etype = pm_etype;
        r.peer  = pm_peer;
    endtask

    // Offer one item, with a random gap between bursts, and record what it should produce.
    task automatic send_item(input logic [1:0] cmd, input logic [7:0] data, input logic last,
                             input logic [7:0] st, input logic [1:0] widx,
                             input logic typed, input ppr_result_t want);
        int          gap;
        logic        has;
        ppr_result_t got;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = (gaps_on != 0) ? $urandom_range(0, 12) : 0;
            if (gap > 0) begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge aclk);
            end
        end
        burst_left--;
        s_tvalid <= 1'b1;
        s_tuser  <= cmd;
        s_tlast  <= last;
        s_tdata  <= {6'b0, widx, st, data};
        do @(posedge aclk); while (!s_tready);
        advance_pairing(cmd, data, last, st, widx, has, got);
        if (has) awaited_results.push_back(typed ? want : got);
        sent_items++;
    endtask

    // Send a packet built from the current header, with one header byte spoilt if asked.
    task automatic send_packet(input int len, input int bad_at, input logic [7:0] chan,
                               input logic [7:0] ptype, input logic [7:0] flags,
                               input logic [31:0] id, input logic [31:0] peer);
        logic [7:0] b;
        for (int p = 0; p < len; p++) begin
            if (p < int'(POS_SHORT_END))
                b = c_hdr_lo[8*p +: 8];
            else if (p < int'(POS_HDR_END))
                b = c_hdr_hi[8*(p-int'(POS_SHORT_END)) +: 8];
            else if (p < int'(POS_ID_END))
                b = id[8*(p-int'(POS_ID)) +: 8];
            else if (p == int'(POS_CHANNEL))
                b = chan;
            else if (p == int'(POS_TYPE))
                b = ptype;
            else if (p == int'(POS_FLAGS))
                b = flags;
            else if (p >= int'(POS_PEER) && p < int'(POS_PEER_END))
                b = peer[8*(p-int'(POS_PEER)) +: 8];
            else
                b = 8'($urandom);
            if (p == bad_at) b = b ^ 8'($urandom_range(1, 255));
            send_item(CMD_BYTE, b, (p == len - 1), 8'($urandom), 2'($urandom), 1'b0, '0);
        end
    endtask

    // Write one register; the caller lowers cfg_valid after its last write.
    task automatic write_reg(input logic [2:0] idx, input logic [47:0] data);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= data;
        do @(posedge aclk); while (!cfg_ready);
        case (idx)
            CFG_HEADER_LOW:         c_hdr_lo = data;
            CFG_HEADER_HIGH:        c_hdr_hi = data[31:0];
            CFG_OWN_DEVICE_ID:      c_own    = data[31:0];
            CFG_CODE_BOND:          c_bond   = data[7:0];
            CFG_CODE_UNBOND:        c_unbond = data[7:0];
            CFG_CODE_UNBOND_FORCE:  c_force  = data[7:0];
            CFG_CODE_BOND_DEVICE:   c_bdev   = data[7:0];
            default:                c_udev   = data[7:0];
        endcase
    endtask

    // Hold the sender until every awaited result is back and the pipeline is quiet.
    task automatic pause_until_drained();
        s_tvalid <= 1'b0;
        while (awaited_results.size() != 0) @(posedge aclk);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // A type code that is likely to mean something to the current pairing state.
    function automatic logic [7:0] pick_code();
        case ($urandom_range(0, 6))
            0:       return c_bond;
            1:       return c_unbond;
            2:       return c_force;
            3:       return c_bdev;
            4:       return c_udev;
            5:       return pm_etype;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic row_t item_row(input logic [1:0] cmd, input logic [7:0] arg,
                                      input logic last);
        row_t r;
        r        = '{default: '0};
        r.cmd    = cmd;
        r.arg    = arg;
        r.last   = last;
        r.bad_at = -1;
        return r;
    endfunction

    function automatic row_t pkt_row(input int len, input int bad_at, input logic [7:0] chan,
                                     input logic [7:0] ptype, input logic [7:0] flags,
                                     input logic [31:0] id, input logic [31:0] peer);
        row_t r;
        r        = '{default: '0};
        r.is_pkt = 1'b1;
        r.len    = len;
        r.bad_at = bad_at;
        r.chan   = chan;
        r.ptype  = ptype;
        r.flags  = flags;
        r.id     = id;
        r.peer   = peer;
        return r;
    endfunction

    // Attach a result that is obvious from the row alone (no action, nothing latched).
    function automatic row_t known(input row_t r, input logic kind, input logic [2:0] mode,
                                   input logic [7:0] etype);
        r.typed      = 1'b1;
        r.want       = '0;
        r.want.kind  = kind;
        r.want.mode  = mode;
        r.want.etype = etype;
        return r;
    endfunction

    // Receiver readiness: always ready, random, a fixed pattern or long stalls.
    always @(posedge aclk) begin
        ready_tick <= ready_tick + 1;
        case (ready_style)
            0: m_tready <= 1'b1;
            1: m_tready <= ($urandom_range(0, 9) < 7);
            2: m_tready <= (ready_tick % 5 != 2) && (ready_tick % 13 < 9);
            default: begin
                if (stall_left != 0) begin
                    stall_left <= stall_left - 1;
                    m_tready   <= 1'b0;
                end else if ($urandom_range(0, 15) == 0) begin
                    stall_left <= $urandom_range(4, 40);
                    m_tready   <= 1'b0;
                end else begin
                    m_tready <= 1'b1;
                end
            end
        endcase
    end

    task automatic check_field(input string name, input logic [31:0] exp_v,
                               input logic [31:0] got_v);
        if (exp_v !== got_v) begin
            $error("%s: expected 0x%0h, got 0x%0h", name, exp_v, got_v);
            mismatches++;
        end
    endtask

    // Compare each accepted result with the oldest awaited one.
    always @(posedge aclk) begin : result_check
        ppr_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (awaited_results.size() == 0) begin
                $error("result with nothing awaited: tuser 0x%0h tdata 0x%0h", m_tuser, m_tdata);
                mismatches++;
            end else begin
                want = awaited_results.pop_front();
                check_field("result_kind",     32'(want.kind),    32'(m_tuser));
                check_field("mode_now",        32'(want.mode),    32'(m_tdata[2:0]));
                check_field("restart_receive", 32'(want.restart), 32'(m_tdata[3]));
                check_field("channel_marked",  32'(want.marked),  32'(m_tdata[4]));
                check_field("entered_bond",    32'(want.entered), 32'(m_tdata[5]));
                check_field("expected_type",   32'(want.etype),   32'(m_tdata[13:6]));
                check_field("peer_id",         want.peer,         m_tdata[45:14]);
                check_field("bitmap_word",     want.word,         m_tdata[77:46]);
            end
        end
    end

    // Watchdog: too long without any handshake on any channel ends the run.
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready) ||
            (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        row_t        plan [$];
        logic [47:0] hdr_lo;
        logic [31:0] hdr_hi, own;
        logic [7:0]  cb, cu, cf, cbd, cud;
        logic [7:0]  chan, ptype, flags;
        logic [31:0] id, peer;
        int          phase_end, pick, len, bad;

        repeat (10) @(posedge aclk);
        aresetn <= 1'b1;

        // Directed rows, run with the register reset values (header and own id all zero).
        plan.push_back(known(item_row(CMD_BYTE, 8'h00, 1'b1), KIND_VERDICT, MODE_IDLE, 8'h00));
        plan.push_back(known(item_row(CMD_READ_WORD, 8'h00, 1'b0), KIND_WORD, MODE_IDLE, 8'h00));
        plan.push_back(known(item_row(CMD_READ_WORD, 8'hFF, 1'b1), KIND_WORD, MODE_IDLE, 8'h00));
        plan.push_back(item_row(CMD_START_SCAN, 8'h00, 1'b0));
        plan.push_back(item_row(CMD_BYTE, 8'hFF, 1'b0));
        plan.push_back(known(item_row(CMD_BYTE, 8'hA5, 1'b1), KIND_VERDICT, MODE_SCAN, 8'h00));
        plan.push_back(pkt_row(24, -1, 8'd0,   8'h00, 8'h00, '0, '0));
        plan.push_back(pkt_row(24, -1, 8'd127, 8'hFF, 8'hFF, '1, '1));
        plan.push_back(pkt_row(40, -1, 8'd37,  8'h00, 8'h00, '0, '0));  // overlong
        plan.push_back(pkt_row(23, -1, 8'd9,   8'h00, 8'h00, '0, '0));  // one byte short
        plan.push_back(pkt_row(24, -1, 8'd255, 8'h00, 8'h00, '0, '0));  // channel off the map
        plan.push_back(pkt_row(24, 2,  8'd50,  8'h00, 8'h00, '0, '0));  // header mismatch
        plan.push_back(item_row(CMD_READ_WORD, 8'h01, 1'b0));
        plan.push_back(item_row(CMD_READ_WORD, 8'h03, 1'b0));
        plan.push_back(item_row(CMD_START_SCAN, 8'hFF, 1'b1));
        plan.push_back(known(item_row(CMD_READ_WORD, 8'h03, 1'b0), KIND_WORD, MODE_SCAN, 8'h00));
        plan.push_back(item_row(CMD_START_BOND, 8'hFF, 1'b0));
        plan.push_back(known(item_row(CMD_READ_WORD, 8'h02, 1'b0), KIND_WORD, MODE_BONDING,
                             8'hFF));
        plan.push_back(item_row(CMD_START_BOND, RST_CODE_BOND, 1'b0));
        plan.push_back(pkt_row(24, -1, 8'd3, RST_CODE_BOND, 8'h00, '0, '0));  // receiver clear
        plan.push_back(pkt_row(24, 7,  8'd3, RST_CODE_BOND, FLAG_RECEIVER, '0, '0));
        plan.push_back(pkt_row(24, -1, 8'd3, RST_CODE_BOND, FLAG_RECEIVER, 32'h12345678, '0));
        plan.push_back(pkt_row(24, -1, 8'd3, RST_CODE_BOND, 8'hFF, '0, 32'hDEADBEEF));
        plan.push_back(pkt_row(24, -1, 8'd3, RST_CODE_BOND, 8'hFF, '0, 32'hDEADBEEF));
        plan.push_back(item_row(CMD_START_BOND, RST_CODE_BOND_DEVICE, 1'b0));
        plan.push_back(pkt_row(26, -1, 8'd3, RST_CODE_BOND_DEVICE, FLAG_RECEIVER | FLAG_FINISH,
                               '0, 32'hDEADBEEF));
        plan.push_back(item_row(CMD_START_BOND, RST_CODE_UNBOND_FORCE, 1'b0));
        plan.push_back(pkt_row(24, -1, 8'd3, RST_CODE_UNBOND_FORCE, FLAG_RECEIVER, '0, '0));
        plan.push_back(item_row(CMD_START_BOND, RST_CODE_UNBOND_DEVICE, 1'b0));
        plan.push_back(pkt_row(24, -1, 8'd3, RST_CODE_UNBOND_DEVICE, FLAG_RECEIVER | FLAG_FINISH,
                               '0, 32'h12345678));  // wrong peer
        plan.push_back(pkt_row(24, -1, 8'd3, 8'h07, FLAG_RECEIVER, '0, '0));  // unknown type

        foreach (plan[i]) begin
            if (plan[i].is_pkt)
                send_packet(plan[i].len, plan[i].bad_at, plan[i].chan, plan[i].ptype,
                            plan[i].flags, plan[i].id, plan[i].peer);
            else
                send_item(plan[i].cmd, plan[i].arg, plan[i].last, plan[i].arg,
                          plan[i].arg[1:0], plan[i].typed, plan[i].want);
        end

        // Random phases, each under a fresh register setting.
        for (int ph = 0; ph < PHASES; ph++) begin
            pause_until_drained();
            if (ph == 0) begin
                hdr_lo = '0; hdr_hi = '0; own = '0;
                cb = '0; cu = '0; cf = '0; cbd = '0; cud = '0;
            end else if (ph == 1) begin
                hdr_lo = '1; hdr_hi = '1; own = '1;
                cb = '1; cu = '1; cf = '1; cbd = '1; cud = '1;
            end else begin
                hdr_lo = {16'($urandom), 32'($urandom)};
                hdr_hi = $urandom;
                own    = $urandom;
                cb  = 8'($urandom); cu  = 8'($urandom); cf = 8'($urandom);
                cbd = 8'($urandom); cud = 8'($urandom);
                // Type codes that overlap between request and confirmation.
                if (ph == 3) cbd = cb;
                if (ph == 4) cud = cf;
            end
            write_reg(CFG_HEADER_LOW,         hdr_lo);
            write_reg(CFG_HEADER_HIGH,        {16'($urandom), hdr_hi});
            write_reg(CFG_OWN_DEVICE_ID,      {16'($urandom), own});
            write_reg(CFG_CODE_BOND,          {8'($urandom), 32'($urandom), cb});
            write_reg(CFG_CODE_UNBOND,        {8'($urandom), 32'($urandom), cu});
            write_reg(CFG_CODE_UNBOND_FORCE,  {8'($urandom), 32'($urandom), cf});
            write_reg(CFG_CODE_BOND_DEVICE,   {8'($urandom), 32'($urandom), cbd});
            write_reg(CFG_CODE_UNBOND_DEVICE, {8'($urandom), 32'($urandom), cud});
            cfg_valid <= 1'b0;

            ready_style = ph % 4;
            gaps_on     = (ph != 2);
            phase_end   = sent_items + PHASE_ITEMS;

            // Mostly well-formed packets, with commands, reads and stray bytes mixed in.
            while (sent_items < phase_end) begin
                pick = $urandom_range(0, 99);
                if (pick < 4) begin
                    send_item(CMD_START_SCAN, 8'($urandom), 1'($urandom), 8'($urandom),
                              2'($urandom), 1'b0, '0);
                end else if (pick < 11) begin
                    send_item(CMD_START_BOND, 8'($urandom), 1'($urandom), pick_code(),
                              2'($urandom), 1'b0, '0);
                end else if (pick < 19) begin
                    send_item(CMD_READ_WORD, 8'($urandom), 1'($urandom), 8'($urandom),
                              2'($urandom), 1'b0, '0);
                end else if (pick < 25) begin
                    send_item(CMD_BYTE, 8'($urandom), 1'($urandom), 8'($urandom),
                              2'($urandom), 1'b0, '0);
                end else begin
                    pick = $urandom_range(0, 99);
                    if (pick < 10)
                        len = $urandom_range(1, 23);
                    else if (pick < 20)
                        len = $urandom_range(25, 40);
                    else
                        len = $urandom_range(24, 26);
                    bad   = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 9) : -1;
                    chan  = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                        : 8'($urandom_range(0, 127));
                    ptype = pick_code();
                    flags = 8'($urandom);
                    if ($urandom_range(0, 3) != 0) flags = flags | FLAG_RECEIVER;
                    if ($urandom_range(0, 1) != 0) flags = flags | FLAG_FINISH;
                    id    = ($urandom_range(0, 4) != 0) ? c_own : $urandom;
                    peer  = ($urandom_range(0, 1) != 0) ? pm_peer : $urandom;
                    send_packet(len, bad, chan, ptype, flags, id, peer);
                end
            end
        end

        pause_until_drained();
        if (mismatches == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule

/* files.f */
rtl/ppr_pkg.sv
rtl/ppr_bitmap.sv
rtl/pairing_packet_receiver.sv
test/tb_pairing_packet_receiver.sv
